### src/stpa_pkg.sv
// ----------------------------------------------------------------------------
// stpa_pkg
// Types and codes shared by the sparse two-variable polynomial adder.
// ----------------------------------------------------------------------------
`default_nettype none

package stpa_pkg;

    localparam int EXP_W      = 4;
    localparam int COEF_W     = 32;
    localparam int SUM_W      = COEF_W + 1;
    localparam int DIM        = 16;
    localparam int ADDR_W     = 2 * EXP_W;
    localparam int RESULT_CAP = 32;

    typedef logic [1:0]               action_t;
    typedef logic [EXP_W-1:0]         exp_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [ADDR_W-1:0]        addr_t;

    localparam action_t ACT_LOAD_FIRST  = 2'd0;
    localparam action_t ACT_LOAD_SECOND = 2'd1;
    localparam action_t ACT_FINISH      = 2'd2;

endpackage

`default_nettype wire

### src/stpa_if.sv
// ----------------------------------------------------------------------------
// stpa_term_if / stpa_sum_if
// Valid/ready channels for term requests and summed result requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface stpa_term_if;
    import stpa_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    exp_t    row_exp;
    exp_t    col_exp;
    coef_t   coefficient;

    modport source (output valid, output action, output row_exp, output col_exp,
                    output coefficient, input ready);
    modport sink   (input valid, input action, input row_exp, input col_exp,
                    input coefficient, output ready);
endinterface

interface stpa_sum_if;
    import stpa_pkg::*;

    logic valid;
    logic ready;
    sum_t sum_coefficient;
    exp_t sum_row_exp;
    exp_t sum_col_exp;
    logic has_term;
    logic overflowed;
    logic last;

    modport source (output valid, output sum_coefficient, output sum_row_exp,
                    output sum_col_exp, output has_term, output overflowed,
                    output last, input ready);
    modport sink   (input valid, input sum_coefficient, input sum_row_exp,
                    input sum_col_exp, input has_term, input overflowed,
                    input last, output ready);
endinterface

`default_nettype wire

### src/sparse_two_var_polynomial_add_core.sv
// ----------------------------------------------------------------------------
// sparse_two_var_polynomial_add_core
// Adds two sparse polynomials in two variables held in dense coefficient RAMs.
// ----------------------------------------------------------------------------
// term_in carries requests. A load (first or second polynomial) writes one
// coefficient at (row_exp, col_exp); loads may come back to back.
// Exponents above LIM = min(MAX_DEGREE, 15) are dropped. A finish scans every
// pair up to LIM in row-major order, one RAM read a cycle, zeroing each entry
// behind the read, and emits each nonzero sum on sum_out, last marking the
// final request; an all-zero sum gives one empty request. At most MAX_TERMS
// terms (no more than 32) are emitted, with overflowed set on every result of
// that finish if more existed.
// After the scan, each result is read from a small result RAM (EMIT_RD) and
// loaded into the output register (EMIT_LD) once that register is free.
// A stalled sum_out holds its request. term_in is not ready during scan and
// emit, and is ready again once the last result sits in the output register,
// even while that one stalls.
// Reset: a clearing pass zeroes every (row, col) entry up to LIM in both
// RAMs, with term_in held not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_two_var_polynomial_add_core #(
    parameter int MAX_DEGREE = 15,
    parameter int MAX_TERMS  = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    stpa_term_if.sink  term_in,
    stpa_sum_if.source sum_out
);
    import stpa_pkg::*;

    // Effective degree limit and term cap
    localparam int LIM   = (MAX_DEGREE > DIM - 1) ? DIM - 1 : MAX_DEGREE;
    localparam int CAP   = (MAX_TERMS > RESULT_CAP) ? RESULT_CAP : MAX_TERMS;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam exp_t LIM_E = EXP_W'(LIM);
    localparam int ENTRY_W = SUM_W + 2 * EXP_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_EMIT_RD = 3'd2;
    localparam logic [2:0] ST_EMIT_LD = 3'd3;
    localparam logic [2:0] ST_CLEAR   = 3'd4;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [2:0]           state_reg, state_next;
    exp_t                 scan_row_reg, scan_row_next;
    exp_t                 scan_col_reg, scan_col_next;
    logic                 issue_done_reg, issue_done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 over_reg, over_next;
    logic [IDX_W-1:0]     emit_idx_reg, emit_idx_next;

    // Scan read stage
    logic                 rd_vld_reg, rd_vld_next;
    logic                 rd_last_reg, rd_last_next;
    exp_t                 rd_row_reg, rd_col_reg;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    sum_t                 out_sum_reg;
    exp_t                 out_row_reg, out_col_reg;
    logic                 out_has_reg, out_over_reg, out_last_reg;
    logic                 out_load;
    sum_t                 out_sum_d;
    exp_t                 out_row_d, out_col_d;
    logic                 out_has_d, out_last_d;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    coef_t                first_mem [DIM*DIM];
    coef_t                second_mem [DIM*DIM];
    logic [ENTRY_W-1:0]   res_mem [CAP];
    coef_t                first_q, second_q;
    logic [ENTRY_W-1:0]   res_q;

    logic                 in_acc;
    logic                 load_ok;
    logic                 first_we, second_we;
    logic                 clr_we;
    addr_t                load_addr, scan_addr;
    logic                 res_we;
    logic [IDX_W-1:0]     res_wa;
    logic [ENTRY_W-1:0]   res_wd;
    sum_t                 sum_val;
    logic                 slot_free;
    logic                 is_last_term;

    assign in_acc    = term_in.valid && term_in.ready;
    assign load_ok   = (term_in.row_exp <= LIM_E) && (term_in.col_exp <= LIM_E);
    assign load_addr = {term_in.row_exp, term_in.col_exp};
    assign scan_addr = {scan_row_reg, scan_col_reg};
    assign first_we  = in_acc && (term_in.action == ACT_LOAD_FIRST) && load_ok;
    assign second_we = in_acc && (term_in.action == ACT_LOAD_SECOND) && load_ok;

    // Loads only land while idle; clearing only runs in the clear and scan
    // states, so the two never share a cycle. A clear zeroes the entry that
    // is read in the same cycle, and the read returns the old contents.
    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[load_addr] <= term_in.coefficient;
        end
        else if (clr_we)
        begin
            first_mem[scan_addr] <= '0;
        end
        first_q <= first_mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        if (second_we)
        begin
            second_mem[load_addr] <= term_in.coefficient;
        end
        else if (clr_we)
        begin
            second_mem[scan_addr] <= '0;
        end
        second_q <= second_mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_wa] <= res_wd;
        end
        res_q <= res_mem[emit_idx_reg];
    end

    // Exact sum of the two coefficients
    assign sum_val = {first_q[COEF_W-1], first_q} + {second_q[COEF_W-1], second_q};

    assign slot_free    = !out_valid_reg || sum_out.ready;
    assign is_last_term = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == cnt_reg;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        scan_row_next   = scan_row_reg;
        scan_col_next   = scan_col_reg;
        issue_done_next = issue_done_reg;
        cnt_next        = cnt_reg;
        over_next       = over_reg;
        emit_idx_next   = emit_idx_reg;
        rd_vld_next     = 1'b0;
        rd_last_next    = 1'b0;
        clr_we          = 1'b0;
        res_we          = 1'b0;
        res_wa          = cnt_reg[IDX_W-1:0];
        res_wd          = {sum_val, rd_row_reg, rd_col_reg};
        out_load        = 1'b0;
        out_sum_d       = res_q[ENTRY_W-1 -: SUM_W];
        out_row_d       = res_q[2*EXP_W-1 -: EXP_W];
        out_col_d       = res_q[EXP_W-1:0];
        out_has_d       = 1'b1;
        out_last_d      = is_last_term;

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one entry of both RAMs per cycle up to the degree limit
                clr_we = 1'b1;
                if (scan_col_reg == LIM_E)
                begin
                    scan_col_next = '0;
                    if (scan_row_reg == LIM_E)
                    begin
                        scan_row_next = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        scan_row_next = scan_row_reg + EXP_W'(1);
                    end
                end
                else
                begin
                    scan_col_next = scan_col_reg + EXP_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_acc && (term_in.action == ACT_FINISH))
                begin
                    state_next      = ST_SCAN;
                    scan_row_next   = '0;
                    scan_col_next   = '0;
                    issue_done_next = 1'b0;
                    cnt_next        = '0;
                    over_next       = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle in row-major order, zeroing behind it
                if (!issue_done_reg)
                begin
                    clr_we       = 1'b1;
                    rd_vld_next  = 1'b1;
                    rd_last_next = (scan_row_reg == LIM_E) && (scan_col_reg == LIM_E);
                    if (scan_col_reg == LIM_E)
                    begin
                        scan_col_next = '0;
                        scan_row_next = scan_row_reg + EXP_W'(1);
                    end
                    else
                    begin
                        scan_col_next = scan_col_reg + EXP_W'(1);
                    end
                    if (rd_last_next)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                // Collect nonzero sums into the result RAM; drop past the cap
                if (rd_vld_reg)
                begin
                    if (sum_val != '0)
                    begin
                        if (cnt_reg < CNT_W'(CAP))
                        begin
                            res_we   = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            over_next = 1'b1;
                        end
                    end
                    if (rd_last_reg)
                    begin
                        state_next    = ST_EMIT_RD;
                        emit_idx_next = '0;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        out_sum_d  = '0;
                        out_row_d  = '0;
                        out_col_d  = '0;
                        out_has_d  = 1'b0;
                        out_last_d = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (is_last_term)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (sum_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            issue_done_reg <= 1'b0;
            cnt_reg        <= '0;
            over_reg       <= 1'b0;
            emit_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_row_reg   <= scan_row_next;
            scan_col_reg   <= scan_col_next;
            issue_done_reg <= issue_done_next;
            cnt_reg        <= cnt_next;
            over_reg       <= over_next;
            emit_idx_reg   <= emit_idx_next;
            rd_vld_reg     <= rd_vld_next;
            rd_last_reg    <= rd_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload: hold read-stage tags and output fields without reset
    always_ff @(posedge clk)
    begin
        rd_row_reg <= scan_row_reg;
        rd_col_reg <= scan_col_reg;
        if (out_load)
        begin
            out_sum_reg  <= out_sum_d;
            out_row_reg  <= out_row_d;
            out_col_reg  <= out_col_d;
            out_has_reg  <= out_has_d;
            out_over_reg <= over_reg;
            out_last_reg <= out_last_d;
        end
    end

    // The overflow flag of an empty result is always clear: over_reg can
    // only be set once the cap is reached, so cnt_reg is nonzero then.
    assign term_in.ready           = (state_reg == ST_IDLE);
    assign sum_out.valid           = out_valid_reg;
    assign sum_out.sum_coefficient = out_sum_reg;
    assign sum_out.sum_row_exp     = out_row_reg;
    assign sum_out.sum_col_exp     = out_col_reg;
    assign sum_out.has_term        = out_has_reg;
    assign sum_out.overflowed      = out_over_reg;
    assign sum_out.last            = out_last_reg;

endmodule

`default_nettype wire

### src/stpa_checker.sv
// ----------------------------------------------------------------------------
// stpa_checker
// Port-level checks on the sparse polynomial adder, bound into the adder core.
// ----------------------------------------------------------------------------
`default_nettype none

module stpa_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire stpa_pkg::action_t in_action,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire stpa_pkg::sum_t out_sum_coefficient,
    input wire stpa_pkg::exp_t out_sum_row_exp,
    input wire stpa_pkg::exp_t out_sum_col_exp,
    input wire logic           out_has_term,
    input wire logic           out_overflowed,
    input wire logic           out_last
);
    import stpa_pkg::*;

    // Hold a stalled result request unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sum_coefficient)
            && $stable(out_sum_row_exp) && $stable(out_sum_col_exp)
            && $stable(out_has_term) && $stable(out_overflowed) && $stable(out_last))
        else $error("stalled result request changed");

    // An empty result is the sole, final result of its finish and carries nothing
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_has_term |-> out_last && !out_overflowed
            && (out_sum_coefficient == '0) && (out_sum_row_exp == '0)
            && (out_sum_col_exp == '0))
        else $error("malformed empty result");

    // A term result never carries a zero sum
    a_term_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_has_term |-> out_sum_coefficient != '0)
        else $error("zero sum emitted as a term");

    // A finish starts the scan, so no request is taken in the next cycle
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == ACT_FINISH) |=> !in_ready)
        else $error("request taken during scan");

endmodule

bind sparse_two_var_polynomial_add_core stpa_checker u_stpa_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (term_in.valid),
    .in_ready            (term_in.ready),
    .in_action           (term_in.action),
    .out_valid           (sum_out.valid),
    .out_ready           (sum_out.ready),
    .out_sum_coefficient (sum_out.sum_coefficient),
    .out_sum_row_exp     (sum_out.sum_row_exp),
    .out_sum_col_exp     (sum_out.sum_col_exp),
    .out_has_term        (sum_out.has_term),
    .out_overflowed      (sum_out.overflowed),
    .out_last            (sum_out.last)
);

`default_nettype wire
